>>> hdl/access_list_entry_table_top_assert.svh
// Assertion helpers shared by the access-list entry table RTL.
`ifndef ACCESS_LIST_ENTRY_TABLE_TOP_ASSERT_SVH
`define ACCESS_LIST_ENTRY_TABLE_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define ALET_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define ALET_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/aclet_pkg.sv
package aclet_pkg;

    // Opcodes of the input word.
    localparam logic [2:0] OP_PUT      = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_CLEAR    = 3'd2;
    localparam logic [2:0] OP_FINALIZE = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    // Tag kinds.
    localparam logic [2:0] TAG_OWNER  = 3'd0;
    localparam logic [2:0] TAG_NUSER  = 3'd1;
    localparam logic [2:0] TAG_OGROUP = 3'd2;
    localparam logic [2:0] TAG_NGROUP = 3'd3;
    localparam logic [2:0] TAG_MASK   = 3'd4;
    localparam logic [2:0] TAG_OTHER  = 3'd5;

    // Status codes of the result word.
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_NOTFOUND = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_INVALID  = 3'd3;
    localparam logic [2:0] STS_TOOMANY  = 3'd4;

    localparam logic [31:0] NO_ID     = 32'hFFFF_FFFF;
    localparam logic [2:0]  PERM_NONE = 3'd7;

    // Configuration port.
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_W           = 6;
    localparam int         LIMIT_W         = 6;
    localparam logic [0:0] CFG_ENTRY_LIMIT = 1'b0;
    localparam logic [0:0] CFG_AUTO_MASK   = 1'b1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd25;

    typedef struct packed {
        logic [2:0]  tag;
        logic [31:0] id;
        logic [2:0]  perm;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    function automatic logic is_named(input logic [2:0] tag);
        return (tag == TAG_NUSER) || (tag == TAG_NGROUP);
    endfunction

endpackage

>>> hdl/aclet_store.sv
module aclet_store #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            aclk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output aclet_pkg::entry_t rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  aclet_pkg::entry_t wr_data
);
    import aclet_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/access_list_entry_table_top.sv
// Access-list entry table. Entries live in a table with one read and one write port. A single
// tag/id comparator walks that table one entry per clock, so the time for a word grows with n,
// the number of entries held:
// - A put walks the table until it finds its entry and overwrites it, or appends when there is room.
// - A remove walks the whole table when it misses. When it hits, the entries behind the
//   removed one are then moved down one per clock; there are none when it hits the last entry.
// - A finalize walks the whole table only when it derives the mask entry.
// - A read fetches the entry at its index, unless the index is out of range.
// - A clear, a put or remove with an unknown tag, and an unknown opcode touch no entry.
// The longest words are a remove that hits any entry but the last and a finalize that
// derives the mask. One word is in work at a time. The next word is taken on the clock
// after the previous result has been placed in the output register, even if that result has
// not yet been taken. A result that is still waiting holds the block in its last step.
// Configuration writes complete in the cycle they are presented.
module access_list_entry_table_top #(
    parameter int CAPACITY = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_opcode,
    input  logic [2:0]                      s_tag,
    input  logic [31:0]                     s_principal_id,
    input  logic [2:0]                      s_perm,
    input  logic [4:0]                      s_index,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic [5:0]                      m_entry_count,
    output logic [2:0]                      m_mask_perm,
    output logic                            m_has_named,
    output logic [2:0]                      m_out_tag,
    output logic [31:0]                     m_out_id,
    output logic [2:0]                      m_out_perm,
    input  logic                            cfg_we,
    input  logic [aclet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aclet_pkg::CFG_W-1:0]     cfg_data
);
    import aclet_pkg::*;

    `include "access_list_entry_table_top_assert.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int RW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    state_t state_reg, state_next;

    logic [2:0]         op_reg, op_next;
    logic [2:0]         tag_reg, tag_next;
    logic [31:0]        id_reg, id_next;
    logic [2:0]         perm_reg, perm_next;
    logic [4:0]         idx_reg, idx_next;

    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      named_cnt_reg, named_cnt_next;
    logic               mask_touched_reg, mask_touched_next;
    logic               mask_present_reg, mask_present_next;
    logic [2:0]         mask_perm_reg, mask_perm_next;
    logic               owner_reg, owner_next;
    logic               ogroup_reg, ogroup_next;
    logic               other_reg, other_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               auto_mask_reg, auto_mask_next;

    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               rvld_reg, rvld_next;
    logic [AW-1:0]      raddr_reg, raddr_next;
    logic [AW-1:0]      mask_idx_reg, mask_idx_next;
    logic [2:0]         or_acc_reg, or_acc_next;

    logic [2:0]         status_reg, status_next;
    logic [2:0]         res_tag_reg, res_tag_next;
    logic [31:0]        res_id_reg, res_id_next;
    logic [2:0]         res_perm_reg, res_perm_next;

    logic               m_valid_reg, m_valid_next;
    logic [2:0]         m_status_reg, m_status_next;
    logic [5:0]         m_count_reg, m_count_next;
    logic [2:0]         m_mask_perm_reg, m_mask_perm_next;
    logic               m_has_named_reg, m_has_named_next;
    logic [2:0]         m_out_tag_reg, m_out_tag_next;
    logic [31:0]        m_out_id_reg, m_out_id_next;
    logic [2:0]         m_out_perm_reg, m_out_perm_next;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    entry_t             rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;

    logic               hit;
    logic               scan_end;

    aclet_store #(
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign s_ready = (state_reg == S_IDLE);

    // A valid read word matching the search key; only meaningful for put and remove.
    assign hit      = rvld_reg && (rd_data.tag == tag_reg) && (rd_data.id == id_reg);
    assign scan_end = !rvld_reg && (ptr_reg >= fill_reg);

    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        tag_next          = tag_reg;
        id_next           = id_reg;
        perm_next         = perm_reg;
        idx_next          = idx_reg;
        fill_next         = fill_reg;
        named_cnt_next    = named_cnt_reg;
        mask_touched_next = mask_touched_reg;
        mask_present_next = mask_present_reg;
        mask_perm_next    = mask_perm_reg;
        owner_next        = owner_reg;
        ogroup_next       = ogroup_reg;
        other_next        = other_reg;
        limit_next        = limit_reg;
        auto_mask_next    = auto_mask_reg;
        ptr_next          = ptr_reg;
        rvld_next         = rvld_reg;
        raddr_next        = raddr_reg;
        mask_idx_next     = mask_idx_reg;
        or_acc_next       = or_acc_reg;
        status_next       = status_reg;
        res_tag_next      = res_tag_reg;
        res_id_next       = res_id_reg;
        res_perm_next     = res_perm_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_count_next      = m_count_reg;
        m_mask_perm_next  = m_mask_perm_reg;
        m_has_named_next  = m_has_named_reg;
        m_out_tag_next    = m_out_tag_reg;
        m_out_id_next     = m_out_id_reg;
        m_out_perm_next   = m_out_perm_reg;
        rd_en             = 1'b0;
        rd_addr           = ptr_reg[AW-1:0];
        wr_en             = 1'b0;
        wr_addr           = fill_reg[AW-1:0];
        wr_data           = '{tag: tag_reg, id: id_reg, perm: perm_reg};

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENTRY_LIMIT: limit_next     = cfg_data[LIMIT_W-1:0];
                CFG_AUTO_MASK:   auto_mask_next = cfg_data[0];
                default:         limit_next     = limit_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_opcode;
                    tag_next      = s_tag;
                    id_next       = is_named(s_tag) ? s_principal_id : NO_ID;
                    perm_next     = s_perm;
                    idx_next      = s_index;
                    status_next   = STS_OK;
                    res_tag_next  = '0;
                    res_id_next   = '0;
                    res_perm_next = '0;
                    // Any put or remove naming the mask counts as touching it, even on failure.
                    if (((s_opcode == OP_PUT) || (s_opcode == OP_REMOVE))
                            && (s_tag == TAG_MASK)) begin
                        mask_touched_next = 1'b1;
                    end
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                ptr_next    = '0;
                rvld_next   = 1'b0;
                or_acc_next = '0;
                unique case (op_reg)
                    OP_PUT, OP_REMOVE: begin
                        if (tag_reg > TAG_OTHER) begin
                            status_next = STS_INVALID;
                            state_next  = S_FINISH;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        fill_next         = '0;
                        named_cnt_next    = '0;
                        mask_touched_next = 1'b0;
                        mask_present_next = 1'b0;
                        owner_next        = 1'b0;
                        ogroup_next       = 1'b0;
                        other_next        = 1'b0;
                        state_next        = S_FINISH;
                    end
                    OP_FINALIZE: begin
                        if (auto_mask_reg && !mask_touched_reg && (named_cnt_reg != '0)) begin
                            state_next = S_SCAN;
                        end else begin
                            state_next = S_CHECK;
                        end
                    end
                    OP_READ: begin
                        if (RW'(idx_reg) < RW'(fill_reg)) begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(idx_reg);
                            state_next = S_READ;
                        end else begin
                            status_next = STS_NOTFOUND;
                            state_next  = S_FINISH;
                        end
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_SCAN: begin
                if (op_reg == OP_FINALIZE) begin
                    if (rvld_reg) begin
                        if ((rd_data.tag == TAG_OGROUP) || is_named(rd_data.tag)) begin
                            or_acc_next = or_acc_reg | rd_data.perm;
                        end
                        if (rd_data.tag == TAG_MASK) begin
                            mask_idx_next = raddr_reg;
                        end
                    end
                end

                if ((op_reg != OP_FINALIZE) && hit) begin
                    rvld_next = 1'b0;
                    if (op_reg == OP_PUT) begin
                        wr_en   = 1'b1;
                        wr_addr = raddr_reg;
                        if (tag_reg == TAG_MASK) begin
                            mask_perm_next = perm_reg;
                        end
                        state_next = S_FINISH;
                    end else begin
                        ptr_next   = CW'(raddr_reg) + CW'(1);
                        state_next = S_SHIFT;
                    end
                end else if (scan_end) begin
                    if (op_reg == OP_FINALIZE) begin
                        // Derived mask: update the existing one in place, or append if room.
                        wr_data = '{tag: TAG_MASK, id: NO_ID, perm: or_acc_reg};
                        if (mask_present_reg) begin
                            wr_en          = 1'b1;
                            wr_addr        = mask_idx_reg;
                            mask_perm_next = or_acc_reg;
                        end else if (fill_reg < CAP_CNT) begin
                            wr_en             = 1'b1;
                            fill_next         = fill_reg + CW'(1);
                            mask_present_next = 1'b1;
                            mask_perm_next    = or_acc_reg;
                        end
                        state_next = S_CHECK;
                    end else if (op_reg == OP_PUT) begin
                        if (fill_reg == CAP_CNT) begin
                            status_next = STS_FULL;
                        end else begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + CW'(1);
                            if (is_named(tag_reg)) begin
                                named_cnt_next = named_cnt_reg + CW'(1);
                            end
                            if (tag_reg == TAG_OWNER) begin
                                owner_next = 1'b1;
                            end
                            if (tag_reg == TAG_OGROUP) begin
                                ogroup_next = 1'b1;
                            end
                            if (tag_reg == TAG_OTHER) begin
                                other_next = 1'b1;
                            end
                            if (tag_reg == TAG_MASK) begin
                                mask_present_next = 1'b1;
                                mask_perm_next    = perm_reg;
                            end
                        end
                        state_next = S_FINISH;
                    end else begin
                        status_next = STS_NOTFOUND;
                        state_next  = S_FINISH;
                    end
                end else if (ptr_reg < fill_reg) begin
                    rd_en      = 1'b1;
                    raddr_next = ptr_reg[AW-1:0];
                    ptr_next   = ptr_reg + CW'(1);
                    rvld_next  = 1'b1;
                end else begin
                    rvld_next = 1'b0;
                end
            end

            S_SHIFT: begin
                if (scan_end) begin
                    fill_next = fill_reg - CW'(1);
                    if (is_named(tag_reg)) begin
                        named_cnt_next = named_cnt_reg - CW'(1);
                    end
                    if (tag_reg == TAG_OWNER) begin
                        owner_next = 1'b0;
                    end
                    if (tag_reg == TAG_OGROUP) begin
                        ogroup_next = 1'b0;
                    end
                    if (tag_reg == TAG_OTHER) begin
                        other_next = 1'b0;
                    end
                    if (tag_reg == TAG_MASK) begin
                        mask_present_next = 1'b0;
                    end
                    state_next = S_FINISH;
                end else begin
                    // Each word read from position p is written back one place lower.
                    if (rvld_reg) begin
                        wr_en   = 1'b1;
                        wr_addr = raddr_reg - AW'(1);
                        wr_data = rd_data;
                    end
                    if (ptr_reg < fill_reg) begin
                        rd_en      = 1'b1;
                        raddr_next = ptr_reg[AW-1:0];
                        ptr_next   = ptr_reg + CW'(1);
                        rvld_next  = 1'b1;
                    end else begin
                        rvld_next = 1'b0;
                    end
                end
            end

            S_READ: begin
                res_tag_next  = rd_data.tag;
                res_id_next   = rd_data.id;
                res_perm_next = rd_data.perm;
                state_next    = S_FINISH;
            end

            S_CHECK: begin
                if (!(owner_reg && ogroup_reg && other_reg)
                        || ((named_cnt_reg != '0) && !mask_present_reg)) begin
                    status_next = STS_INVALID;
                end else if (MW'(fill_reg) > MW'(limit_reg)) begin
                    status_next = STS_TOOMANY;
                end else begin
                    status_next = STS_OK;
                end
                state_next = S_FINISH;
            end

            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = status_reg;
                    m_count_next     = 6'(fill_reg);
                    m_mask_perm_next = mask_present_reg ? mask_perm_reg : PERM_NONE;
                    m_has_named_next = (named_cnt_reg != '0);
                    m_out_tag_next   = res_tag_reg;
                    m_out_id_next    = res_id_reg;
                    m_out_perm_next  = res_perm_reg;
                    state_next       = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            named_cnt_reg    <= '0;
            mask_touched_reg <= 1'b0;
            mask_present_reg <= 1'b0;
            owner_reg        <= 1'b0;
            ogroup_reg       <= 1'b0;
            other_reg        <= 1'b0;
            limit_reg        <= LIMIT_RESET;
            auto_mask_reg    <= 1'b1;
            rvld_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            named_cnt_reg    <= named_cnt_next;
            mask_touched_reg <= mask_touched_next;
            mask_present_reg <= mask_present_next;
            owner_reg        <= owner_next;
            ogroup_reg       <= ogroup_next;
            other_reg        <= other_next;
            limit_reg        <= limit_next;
            auto_mask_reg    <= auto_mask_next;
            rvld_reg         <= rvld_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        tag_reg         <= tag_next;
        id_reg          <= id_next;
        perm_reg        <= perm_next;
        idx_reg         <= idx_next;
        mask_perm_reg   <= mask_perm_next;
        ptr_reg         <= ptr_next;
        raddr_reg       <= raddr_next;
        mask_idx_reg    <= mask_idx_next;
        or_acc_reg      <= or_acc_next;
        status_reg      <= status_next;
        res_tag_reg     <= res_tag_next;
        res_id_reg      <= res_id_next;
        res_perm_reg    <= res_perm_next;
        m_status_reg    <= m_status_next;
        m_count_reg     <= m_count_next;
        m_mask_perm_reg <= m_mask_perm_next;
        m_has_named_reg <= m_has_named_next;
        m_out_tag_reg   <= m_out_tag_next;
        m_out_id_reg    <= m_out_id_next;
        m_out_perm_reg  <= m_out_perm_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;
    assign m_mask_perm   = m_mask_perm_reg;
    assign m_has_named   = m_has_named_reg;
    assign m_out_tag     = m_out_tag_reg;
    assign m_out_id      = m_out_id_reg;
    assign m_out_perm    = m_out_perm_reg;

    `ALET_ASSERT_ALWAYS(a_fill_in_range, aclk, aresetn, fill_reg <= CAP_CNT, "fill count beyond capacity")
    `ALET_ASSERT_ALWAYS(a_named_le_fill, aclk, aresetn, named_cnt_reg <= fill_reg, "named count beyond fill count")
    `ALET_ASSERT_ALWAYS(a_mask_has_entry, aclk, aresetn, !mask_present_reg || (fill_reg != '0), "mask flagged in an empty table")
    `ALET_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready && (state_reg == S_DISPATCH), "new word taken while busy")
    `ALET_ASSERT_NEXT(a_clear_empties, aclk, aresetn, (state_reg == S_DISPATCH) && (op_reg == OP_CLEAR), (fill_reg == '0) && !mask_touched_reg && (named_cnt_reg == '0), "clear left entries behind")

endmodule
